@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the fade engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RLFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define RLFE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`RLFE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hw/rtl/rlfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rlfe_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned NUM_CH    = 3;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned P_W       = 10;
	localparam int unsigned DVD_W     = LEN_W + P_W;
	localparam int unsigned DIV_STEPS = P_W;
	localparam int unsigned MIX_W     = 18;

	localparam int unsigned PERMILLE  = 1000;
	localparam int unsigned MIX_ROUND = 500;

	// floor(x / 1000) == (x * MIX_RECIP) >> MIX_SHIFT for any x below 2^MIX_W
	localparam int unsigned          RECIP_W   = 19;
	localparam int unsigned          MIX_SHIFT = 28;
	localparam logic [RECIP_W-1:0]   MIX_RECIP = 19'd268436;

	localparam logic [LEN_W-1:0] SOFT_START_RST = 16'd300;
	localparam logic [LEN_W-1:0] SOFT_STOP_RST  = 16'd600;
	localparam logic [LEN_W-1:0] XFADE_RST      = 16'd200;

	typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_APPLY = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SOFT_START = 2'd0,
		REG_SOFT_STOP  = 2'd1,
		REG_CROSSFADE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_PDIV,
		ST_MIXP,
		ST_MDIV,
		ST_CMD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/rlfe_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
// The dividend must be below divisor * 2^P_W.
module rlfe_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rlfe_pkg::div_req_t req,
	output rlfe_pkg::div_rsp_t      rsp
);

	localparam int unsigned CNT_W = $clog2(rlfe_pkg::DIV_STEPS + 1);
	localparam int unsigned LW    = rlfe_pkg::LEN_W;
	localparam int unsigned QW    = rlfe_pkg::P_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LW-1:0]    dvs_q;
	logic [LW-1:0]    rem_q;
	logic [QW-1:0]    num_q;
	logic [LW+1:0]    diff;
	logic             qbit;

	assign diff = {1'b0, rem_q, num_q[QW-1]} - {2'b00, dvs_q};
	assign qbit = !diff[LW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(rlfe_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= req.dividend[rlfe_pkg::DVD_W-1:QW];
			num_q <= req.dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= qbit ? diff[LW-1:0] : {rem_q[LW-2:0], num_q[QW-1]};
			num_q <= {num_q[QW-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

	`RLFE_ASSERT(a_start_sets_busy, clk, arst_n, req.start |=> busy_q, "divider not busy after start")
	`RLFE_ASSERT_NEVER(a_no_restart, clk, arst_n, busy_q && req.start, "divider restarted while busy")

endmodule

`default_nettype wire

@@ hw/rtl/rgb_light_fade_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    command, now_ms, light_mode, red, green, blue
// out       out_valid / out_ready  out_red, out_green, out_blue, fading, color_changed
// cfg       cfg_we                 cfg_index, cfg_data
//
// Fill: from accept straight to the result state; tick or command with no fade running: via
// the advance and command states. Running fade: adds the serial progress divider and a
// rounded blend per color channel (scaled sum, then reciprocal multiply).
// in_ready is high only while idle; a finished result may wait in the output register.
// arst_n clears the fade state and loads the default fade lengths.
module rgb_light_fade_engine_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   command,
	input  wire logic [rlfe_pkg::TIME_W-1:0]  now_ms,
	input  wire logic                         light_mode,
	input  wire logic [rlfe_pkg::CH_W-1:0]    red,
	input  wire logic [rlfe_pkg::CH_W-1:0]    green,
	input  wire logic [rlfe_pkg::CH_W-1:0]    blue,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rlfe_pkg::CH_W-1:0]         out_red,
	output logic [rlfe_pkg::CH_W-1:0]         out_green,
	output logic [rlfe_pkg::CH_W-1:0]         out_blue,
	output logic                              fading,
	output logic                              color_changed,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [rlfe_pkg::LEN_W-1:0]   cfg_data
);

	localparam int unsigned LW = rlfe_pkg::LEN_W;
	localparam int unsigned TW = rlfe_pkg::TIME_W;
	localparam int unsigned QW = rlfe_pkg::P_W;
	localparam int unsigned CW = rlfe_pkg::CH_W;
	localparam int unsigned MW = rlfe_pkg::MIX_W;
	localparam int unsigned DW = rlfe_pkg::DVD_W;
	localparam int unsigned RW = rlfe_pkg::RECIP_W;

	rlfe_pkg::state_t   state_q, state_d;
	rlfe_pkg::div_req_t div_req;
	rlfe_pkg::div_rsp_t div_rsp;

	logic [LW-1:0] soft_start_q, soft_stop_q, xfade_q;

	logic [1:0]       cmd_q;
	logic [TW-1:0]    now_q;
	logic             mode_q;
	rlfe_pkg::color_t color_q, before_q;

	rlfe_pkg::color_t rendered_q, from_q, to_q, tcolor_q;
	logic [LW-1:0]    len_q;
	logic [TW-1:0]    start_q;
	logic             active_q;
	logic             tmode_q;

	logic [QW-1:0] p_q;
	logic [1:0]    ch_q;
	logic [MW-1:0] mix_q;

	logic             out_valid_q;
	rlfe_pkg::color_t out_color_q;
	logic             out_fading_q, out_changed_q;

	rlfe_pkg::color_t  in_color;
	logic [TW-1:0]     elapsed;
	logic              fade_end;
	logic [CW-1:0]     ch_a, ch_b;
	logic signed [CW:0]    dif;
	logic signed [CW+QW+1:0] prod;
	logic [MW-1:0]     base;
	logic [CW+QW+2:0]  mix_sum;
	logic [MW+RW-1:0]  mix_prod;
	logic [CW-1:0]     mix_quo;
	logic              cmd_differs;
	logic [LW-1:0]     new_len;
	logic              out_free;

	assign in_color    = light_mode ? rlfe_pkg::color_t'({red, green, blue}) : '0;
	assign elapsed     = now_q - start_q;
	assign fade_end    = (len_q == '0) || (elapsed >= {{(TW-LW){1'b0}}, len_q});
	assign ch_a        = from_q[ch_q];
	assign ch_b        = to_q[ch_q];
	assign dif         = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
	assign prod        = dif * $signed({1'b0, p_q});
	assign base        = MW'(ch_a) * MW'(rlfe_pkg::PERMILLE) + MW'(rlfe_pkg::MIX_ROUND);
	assign mix_sum     = {{(CW+QW+3-MW){1'b0}}, base} + {prod[CW+QW+1], prod};
	assign mix_prod    = (MW+RW)'(mix_q) * (MW+RW)'(rlfe_pkg::MIX_RECIP);
	assign mix_quo     = mix_prod[rlfe_pkg::MIX_SHIFT +: CW];
	assign cmd_differs = (mode_q != tmode_q) || (color_q != tcolor_q);
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		if (rendered_q == color_q) begin
			new_len = '0;
		end else if (rendered_q == '0) begin
			new_len = soft_start_q;
		end else if (color_q == '0) begin
			new_len = soft_stop_q;
		end else begin
			new_len = xfade_q;
		end
	end

	rlfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		div_req  = '0;
		unique case (state_q)
			rlfe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (command == rlfe_pkg::CMD_FILL) ? rlfe_pkg::ST_DONE
					                                         : rlfe_pkg::ST_ADV;
				end
			end
			rlfe_pkg::ST_ADV: begin
				if (!active_q || fade_end) begin
					state_d = rlfe_pkg::ST_CMD;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DW'(elapsed[LW-1:0]) * DW'(rlfe_pkg::PERMILLE);
					div_req.divisor  = len_q;
					state_d          = rlfe_pkg::ST_PDIV;
				end
			end
			rlfe_pkg::ST_PDIV: begin
				if (div_rsp.done) begin
					state_d = rlfe_pkg::ST_MIXP;
				end
			end
			rlfe_pkg::ST_MIXP: begin
				state_d = rlfe_pkg::ST_MDIV;
			end
			rlfe_pkg::ST_MDIV: begin
				state_d = (ch_q == '0) ? rlfe_pkg::ST_CMD : rlfe_pkg::ST_MIXP;
			end
			rlfe_pkg::ST_CMD: begin
				state_d = rlfe_pkg::ST_DONE;
			end
			rlfe_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rlfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlfe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_start_q <= rlfe_pkg::SOFT_START_RST;
			soft_stop_q  <= rlfe_pkg::SOFT_STOP_RST;
			xfade_q      <= rlfe_pkg::XFADE_RST;
			rendered_q   <= '0;
			from_q       <= '0;
			to_q         <= '0;
			tcolor_q     <= '0;
			len_q        <= '0;
			start_q      <= '0;
			active_q     <= 1'b0;
			tmode_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rlfe_pkg::REG_SOFT_START: soft_start_q <= cfg_data;
					rlfe_pkg::REG_SOFT_STOP:  soft_stop_q  <= cfg_data;
					rlfe_pkg::REG_CROSSFADE:  xfade_q      <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == rlfe_pkg::ST_IDLE && in_valid && command == rlfe_pkg::CMD_FILL) begin
				rendered_q <= in_color;
				from_q     <= in_color;
				to_q       <= in_color;
				tcolor_q   <= in_color;
				tmode_q    <= light_mode;
				len_q      <= '0;
				start_q    <= '0;
				active_q   <= 1'b0;
			end

			if (state_q == rlfe_pkg::ST_ADV && active_q && fade_end) begin
				active_q   <= 1'b0;
				rendered_q <= to_q;
			end

			if (state_q == rlfe_pkg::ST_MDIV) begin
				rendered_q[ch_q] <= mix_quo;
			end

			if (state_q == rlfe_pkg::ST_CMD && cmd_q == rlfe_pkg::CMD_APPLY && cmd_differs) begin
				tmode_q  <= mode_q;
				tcolor_q <= color_q;
				from_q   <= rendered_q;
				to_q     <= color_q;
				len_q    <= new_len;
				start_q  <= now_q;
				if (new_len == '0) begin
					active_q   <= 1'b0;
					rendered_q <= color_q;
				end else begin
					active_q <= 1'b1;
				end
			end

			if (state_q == rlfe_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rlfe_pkg::ST_IDLE && in_valid) begin
			cmd_q    <= command;
			now_q    <= now_ms;
			mode_q   <= light_mode;
			color_q  <= in_color;
			before_q <= rendered_q;
		end
		if (state_q == rlfe_pkg::ST_PDIV && div_rsp.done) begin
			p_q  <= div_rsp.quotient;
			ch_q <= 2'(rlfe_pkg::NUM_CH - 1);
		end
		if (state_q == rlfe_pkg::ST_MIXP) begin
			mix_q <= mix_sum[MW-1:0];
		end
		if (state_q == rlfe_pkg::ST_MDIV) begin
			ch_q <= ch_q - 2'd1;
		end
		if (state_q == rlfe_pkg::ST_DONE && out_free) begin
			out_color_q   <= rendered_q;
			out_fading_q  <= active_q;
			out_changed_q <= (rendered_q != before_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_red       = out_color_q[2];
	assign out_green     = out_color_q[1];
	assign out_blue      = out_color_q[0];
	assign fading        = out_fading_q;
	assign color_changed = out_changed_q;

	`RLFE_ASSERT(a_len_nonzero, clk, arst_n, active_q |-> (len_q != '0), "fade running with zero length")
	`RLFE_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "ready right after accept")
	`RLFE_ASSERT(a_permille_range, clk, arst_n, ((state_q == rlfe_pkg::ST_PDIV) && div_rsp.done) |-> (div_rsp.quotient < QW'(rlfe_pkg::PERMILLE)), "progress out of range")

endmodule

`default_nettype wire

@@ tb/rlfe_fade_checker.sv @@
`timescale 1ns / 1ps

module rlfe_fade_checker
	import rlfe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [1:0]          command,
	input  wire logic [TIME_W-1:0]   now_ms,
	input  wire logic                light_mode,
	input  wire logic [CH_W-1:0]     red,
	input  wire logic [CH_W-1:0]     green,
	input  wire logic [CH_W-1:0]     blue,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire logic [CH_W-1:0]     out_red,
	input  wire logic [CH_W-1:0]     out_green,
	input  wire logic [CH_W-1:0]     out_blue,
	input  wire logic                fading,
	input  wire logic                color_changed,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [LEN_W-1:0]    cfg_data,
	output int unsigned              fail_count,
	output int unsigned              pending_count
);

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            fading;
		logic            changed;
	} light_result_t;

	light_result_t expected_light_q[$];

	logic [LEN_W-1:0]  rise_len;
	logic [LEN_W-1:0]  fall_len;
	logic [LEN_W-1:0]  blend_len;

	color_t            shown_color;
	color_t            blend_from;
	color_t            blend_to;
	color_t            goal_color;
	logic              goal_lit;
	logic              blend_running;
	logic [LEN_W-1:0]  fade_len_cur;
	logic [TIME_W-1:0] fade_t0;

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b, input int unsigned p);
		return 8'((a * (PERMILLE - p) + b * p + MIX_ROUND) / PERMILLE);
	endfunction

	function automatic color_t blend_color(input color_t a, input color_t b,
			input int unsigned p);
		color_t mixed;
		for (int ch = 0; ch < NUM_CH; ch++)
			mixed[ch] = blend_channel(a[ch], b[ch], p);
		return mixed;
	endfunction

	task automatic advance_fade(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] elapsed;
		elapsed = t - fade_t0;
		if (!blend_running)
			return;
		if (fade_len_cur == 0 || elapsed >= fade_len_cur) begin
			blend_running = 1'b0;
			shown_color = blend_to;
		end else begin
			shown_color = blend_color(blend_from, blend_to, (elapsed * PERMILLE) / fade_len_cur);
		end
	endtask

	task automatic retarget(input logic lit, input color_t c, input logic [TIME_W-1:0] t);
		goal_lit = lit;
		goal_color = c;
		blend_from = shown_color;
		blend_to = c;
		if (blend_from == blend_to)
			fade_len_cur = '0;
		else if (blend_from == '0)
			fade_len_cur = rise_len;
		else if (blend_to == '0)
			fade_len_cur = fall_len;
		else
			fade_len_cur = blend_len;
		fade_t0 = t;
		if (fade_len_cur == 0 || blend_from == blend_to) begin
			blend_running = 1'b0;
			shown_color = blend_to;
		end else begin
			blend_running = 1'b1;
		end
	endtask

	task automatic predict_light_step(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
			input logic lit, input color_t req, output light_result_t res);
		color_t prior;
		color_t c;
		prior = shown_color;
		c = lit ? req : '0;
		case (cmd)
			CMD_APPLY: begin
				advance_fade(t);
				if (lit != goal_lit || c != goal_color)
					retarget(lit, c, t);
				advance_fade(t);
			end
			CMD_FILL: begin
				shown_color = c;
				blend_from = c;
				blend_to = c;
				fade_len_cur = '0;
				fade_t0 = '0;
				blend_running = 1'b0;
				goal_lit = lit;
				goal_color = c;
			end
			default: advance_fade(t);
		endcase
		res = {shown_color[2], shown_color[1], shown_color[0], blend_running,
			shown_color != prior};
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		light_result_t seen;
		light_result_t want;
		if (!arst_n) begin
			rise_len = SOFT_START_RST;
			fall_len = SOFT_STOP_RST;
			blend_len = XFADE_RST;
			shown_color = '0;
			blend_from = '0;
			blend_to = '0;
			goal_color = '0;
			goal_lit = 1'b0;
			blend_running = 1'b0;
			fade_len_cur = '0;
			fade_t0 = '0;
			expected_light_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				seen = {out_red, out_green, out_blue, fading, color_changed};
				if (expected_light_q.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected transaction: expected none, actual %h",
						$time, seen);
				end else begin
					want = expected_light_q.pop_front();
					compare_field("out_red", want.r, seen.r);
					compare_field("out_green", want.g, seen.g);
					compare_field("out_blue", want.b, seen.b);
					compare_field("fading", want.fading, seen.fading);
					compare_field("color_changed", want.changed, seen.changed);
				end
			end
			if (in_valid && in_ready) begin
				predict_light_step(command, now_ms, light_mode, {red, green, blue}, want);
				expected_light_q.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SOFT_START: rise_len = cfg_data;
					REG_SOFT_STOP:  fall_len = cfg_data;
					REG_CROSSFADE:  blend_len = cfg_data;
					default: ;
				endcase
			end
		end
		pending_count = expected_light_q.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import rlfe_pkg::*;

	localparam logic [1:0]  CMD_SPARE      = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned HOLD_AT        = 600;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned SETTLE_CYCLES  = 60;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          command;
	logic [TIME_W-1:0]   now_ms;
	logic                light_mode;
	logic [CH_W-1:0]     red;
	logic [CH_W-1:0]     green;
	logic [CH_W-1:0]     blue;
	logic                out_valid;
	logic                out_ready;
	logic [CH_W-1:0]     out_red;
	logic [CH_W-1:0]     out_green;
	logic [CH_W-1:0]     out_blue;
	logic                fading;
	logic                color_changed;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [LEN_W-1:0]    cfg_data;
	int unsigned         fail_count;
	int unsigned         pending_count;

	logic [TIME_W-1:0]   now_cursor;
	color_t              last_goal;
	bit                  tx_burst;
	bit                  rx_burst;
	int unsigned         rx_count;
	int unsigned         quiet_cycles;

	rgb_light_fade_engine_unit DUT (.*);

	rlfe_fade_checker fade_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic offer_light_item(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
			input logic lit, input color_t c);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd;
		now_ms <= t;
		light_mode <= lit;
		red <= c[2];
		green <= c[1];
		blue <= c[0];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_fade_lengths(input logic [LEN_W-1:0] rise,
			input logic [LEN_W-1:0] fall, input logic [LEN_W-1:0] blend);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOFT_START;
		cfg_data <= rise;
		@(negedge clk);
		cfg_index <= REG_SOFT_STOP;
		cfg_data <= fall;
		@(negedge clk);
		cfg_index <= REG_CROSSFADE;
		cfg_data <= blend;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic color_t pick_color();
		color_t c;
		case ($urandom_range(0, 7))
			0: c = '0;
			1: c = '1;
			2: c = last_goal;
			default: begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					case ($urandom_range(0, 5))
						0: c[ch] = '0;
						1: c[ch] = '1;
						default: c[ch] = CH_W'($urandom());
					endcase
				end
			end
		endcase
		return c;
	endfunction

	task automatic directed_fades();
		offer_light_item(CMD_TICK, 32'd0, 1'b0, 24'h000000);
		offer_light_item(CMD_APPLY, 32'd100, 1'b1, 24'hFFFFFF);
		offer_light_item(CMD_TICK, 32'd250, 1'b0, 24'h000000);
		offer_light_item(CMD_TICK, 32'd399, 1'b0, 24'h000000);
		offer_light_item(CMD_APPLY, 32'd400, 1'b1, 24'hFFFFFF);
		// off ignores the requested color
		offer_light_item(CMD_APPLY, 32'd500, 1'b0, 24'hAA5533);
		offer_light_item(CMD_SPARE, 32'd800, 1'b1, 24'hFFFFFF);
		offer_light_item(CMD_APPLY, 32'd900, 1'b1, 24'hFF0000);
		offer_light_item(CMD_TICK, 32'd950, 1'b0, 24'h000000);
		offer_light_item(CMD_FILL, 32'd1000, 1'b0, 24'h123456);
		// black solid vs off: target moves, nothing fades
		offer_light_item(CMD_APPLY, 32'd1010, 1'b1, 24'h000000);
		offer_light_item(CMD_APPLY, 32'd1020, 1'b0, 24'hFFFFFF);
		offer_light_item(CMD_FILL, 32'd1030, 1'b1, 24'h123456);
		offer_light_item(CMD_APPLY, 32'hFFFF_FF00, 1'b1, 24'h00FF00);
		offer_light_item(CMD_TICK, 32'h0000_0010, 1'b0, 24'h000000);
		offer_light_item(CMD_APPLY, 32'h0000_0100, 1'b1, 24'h0000FF);
		// time runs backwards
		offer_light_item(CMD_TICK, 32'h0000_0050, 1'b0, 24'h000000);
		offer_light_item(CMD_FILL, 32'h0000_0060, 1'b1, 24'hFFFFFF);
		offer_light_item(CMD_APPLY, 32'h8000_0000, 1'b0, 24'h000000);
		offer_light_item(CMD_TICK, 32'h8000_012C, 1'b0, 24'h000000);
		offer_light_item(CMD_FILL, 32'h8000_0200, 1'b1, 24'h000000);
		offer_light_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF);
	endtask

	task automatic run_fade_phase(input logic [LEN_W-1:0] rise, input logic [LEN_W-1:0] fall,
			input logic [LEN_W-1:0] blend, input int unsigned count);
		int unsigned reach;
		int unsigned pick;
		logic [1:0]  cmd;
		logic        lit;
		color_t      c;
		reach = rise;
		if (fall > reach)
			reach = fall;
		if (blend > reach)
			reach = blend;
		reach = reach / 6 + 2;
		drain_results();
		write_fade_lengths(rise, fall, blend);
		now_cursor = $urandom();
		repeat (count) begin
			pick = $urandom_range(0, 99);
			lit = ($urandom_range(0, 4) != 0);
			c = pick_color();
			if (pick < 50) begin
				now_cursor += $urandom_range(0, reach);
				cmd = CMD_TICK;
			end else if (pick < 78) begin
				now_cursor += $urandom_range(0, reach / 4);
				cmd = CMD_APPLY;
				if (lit)
					last_goal = c;
			end else if (pick < 86) begin
				cmd = CMD_FILL;
			end else if (pick < 91) begin
				now_cursor += $urandom_range(0, reach);
				cmd = CMD_SPARE;
			end else begin
				if (pick < 95)
					now_cursor = $urandom();
				else
					now_cursor -= $urandom_range(1, reach);
				cmd = (pick % 2) ? CMD_APPLY : CMD_TICK;
			end
			offer_light_item(cmd, now_cursor, lit, c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		now_ms = '0;
		light_mode = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SOFT_START;
		cfg_data = '0;
		last_goal = '0;
		tx_burst = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_fades();
		run_fade_phase(16'd0, 16'd0, 16'd0, 215);
		run_fade_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 215);
		run_fade_phase(16'd1, 16'd1, 16'd1, 215);
		run_fade_phase(16'd0, 16'hFFFF, 16'd1, 215);
		run_fade_phase(16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
			16'($urandom_range(1, 60)), 215);
		run_fade_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 215);
		run_fade_phase(SOFT_START_RST, SOFT_STOP_RST, XFADE_RST, 215);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** rgb_light_fade_engine_unit: PASSED **");
		else
			$display("** rgb_light_fade_engine_unit: FAILED **");
		$finish;
	end

	// result side; one long hold-off lets the block back up into the input
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		rx_burst = 1'b0;
		rx_count = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = (rx_count == HOLD_AT) ? HOLD_CYCLES : (rx_burst ? 0 : $urandom_range(0, 4));
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			rx_count++;
			@(negedge clk);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("** rgb_light_fade_engine_unit: FAILED **");
		$finish;
	end

endmodule
